>>> rtl/irpd_pkg.sv
// Package for the IR remote pulse-interval decoder.
// Holds widths, configuration register indexes, reset values and edge request codes.
// No dependencies.
`default_nettype none

package irpd_pkg;

    localparam int TIMER_WIDTH = 32;
    localparam int FRAME_BITS  = 12;
    localparam int CFG_WIDTH   = 32;
    localparam int CFG_COUNT   = 6;
    localparam int CFG_IDX_W   = $clog2(CFG_COUNT);
    // bit index runs -1 .. FRAME_BITS+1, signed
    localparam int BIT_IDX_W   = $clog2(FRAME_BITS + 2) + 1;
    localparam int BIT_SEL_W   = $clog2(FRAME_BITS);

    typedef logic [TIMER_WIDTH-1:0]      timer_t;
    typedef logic [FRAME_BITS-1:0]       word_t;
    typedef logic signed [BIT_IDX_W-1:0] bit_idx_t;
    typedef logic [CFG_IDX_W-1:0]        cfg_idx_t;
    typedef logic [CFG_WIDTH-1:0]        cfg_data_t;

    localparam cfg_idx_t CFG_START_MIN = CFG_IDX_W'(0);
    localparam cfg_idx_t CFG_START_MAX = CFG_IDX_W'(1);
    localparam cfg_idx_t CFG_ONE_MIN   = CFG_IDX_W'(2);
    localparam cfg_idx_t CFG_ONE_MAX   = CFG_IDX_W'(3);
    localparam cfg_idx_t CFG_STOP_MIN  = CFG_IDX_W'(4);
    localparam cfg_idx_t CFG_STOP_MAX  = CFG_IDX_W'(5);

    localparam timer_t START_MIN_RST = TIMER_WIDTH'(42000);
    localparam timer_t START_MAX_RST = TIMER_WIDTH'(48000);
    localparam timer_t ONE_MIN_RST   = TIMER_WIDTH'(24000);
    localparam timer_t ONE_MAX_RST   = TIMER_WIDTH'(30000);
    localparam timer_t STOP_MIN_RST  = TIMER_WIDTH'(15000);
    localparam timer_t STOP_MAX_RST  = TIMER_WIDTH'(21000);

    typedef enum logic [1:0] {
        EDGE_NONE = 2'd0,
        EDGE_RISE = 2'd1,
        EDGE_FALL = 2'd2
    } edge_req_t;

endpackage

`default_nettype wire

>>> rtl/irpd_if.sv
// Channel interfaces of the IR remote decoder: edge timestamps in, decoded results out.
// Depends on irpd_pkg.
`default_nettype none

interface irpd_in_if
    import irpd_pkg::*;
    ;
    logic   valid;
    logic   ready;
    timer_t edge_time;

    modport source (output valid, output edge_time, input ready);
    modport sink   (input valid, input edge_time, output ready);
endinterface

interface irpd_out_if
    import irpd_pkg::*;
    ;
    logic      valid;
    logic      ready;
    word_t     word_value;
    logic      frame_end;
    logic      frame_valid;
    edge_req_t edge_request;

    modport source (output valid, output word_value, output frame_end,
                    output frame_valid, output edge_request, input ready);
    modport sink   (input valid, input word_value, input frame_end,
                    input frame_valid, input edge_request, output ready);
endinterface

`default_nettype wire

>>> rtl/ir_remote_pulse_decoder_top.sv
// IR remote pulse-interval decoder: one result beat per edge timestamp beat.
// Latency: result beat is valid the cycle after the input beat is accepted.
// Throughput: one beat per cycle while out_ch.ready is high; a new beat is taken while the result register drains.
// Set by the single decode stage: one subtract, six window compares and a counter update.
// Reset (rst_n low, asynchronous): decoder state cleared, windows back to defaults,
// result register empty.
`default_nettype none

module ir_remote_pulse_decoder_top
    import irpd_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    irpd_in_if.sink        in_ch,
    irpd_out_if.source     out_ch,
    input  wire logic      cfg_we,
    input  wire cfg_idx_t  cfg_index,
    input  wire cfg_data_t cfg_data
);

    timer_t start_min_reg, start_max_reg;
    timer_t one_min_reg, one_max_reg;
    timer_t stop_min_reg, stop_max_reg;

    timer_t   last_time_reg, last_time_next;
    logic     active_reg, active_next;
    logic     started_reg, started_next;
    bit_idx_t bit_idx_reg, bit_idx_next;
    word_t    word_reg, word_next;

    logic      out_valid_reg;
    word_t     out_word_reg;
    logic      out_end_reg;
    logic      out_fvalid_reg;
    edge_req_t out_req_reg;

    logic      accept;
    timer_t    interval;
    logic      start_hit, one_hit, stop_hit;
    bit_idx_t  bit_idx_mid;
    logic      started_mid;
    logic      end_now, fvalid_now;
    edge_req_t req_now;

    // Take a new beat whenever the result register is empty or being drained.
    assign in_ch.ready = !out_valid_reg || out_ch.ready;
    assign accept      = in_ch.valid && in_ch.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_min_reg <= START_MIN_RST;
            start_max_reg <= START_MAX_RST;
            one_min_reg   <= ONE_MIN_RST;
            one_max_reg   <= ONE_MAX_RST;
            stop_min_reg  <= STOP_MIN_RST;
            stop_max_reg  <= STOP_MAX_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_START_MIN: start_min_reg <= TIMER_WIDTH'(cfg_data);
                CFG_START_MAX: start_max_reg <= TIMER_WIDTH'(cfg_data);
                CFG_ONE_MIN:   one_min_reg   <= TIMER_WIDTH'(cfg_data);
                CFG_ONE_MAX:   one_max_reg   <= TIMER_WIDTH'(cfg_data);
                CFG_STOP_MIN:  stop_min_reg  <= TIMER_WIDTH'(cfg_data);
                CFG_STOP_MAX:  stop_max_reg  <= TIMER_WIDTH'(cfg_data);
                default: ;
            endcase
        end
    end

    always_comb
    begin
        interval  = in_ch.edge_time - last_time_reg;
        start_hit = (interval > start_min_reg) && (interval < start_max_reg);
        one_hit   = (interval > one_min_reg) && (interval < one_max_reg);
        stop_hit  = (interval > stop_min_reg) && (interval < stop_max_reg);

        // start pulse restarts the frame at index -1
        started_mid = started_reg || start_hit;
        bit_idx_mid = start_hit ? BIT_IDX_W'(-1) : bit_idx_reg;
        word_next   = start_hit ? '0 : word_reg;

        if (started_mid && one_hit && (bit_idx_mid >= 0)
            && (bit_idx_mid < BIT_IDX_W'(FRAME_BITS)))
        begin
            word_next = word_next | (word_t'(1) << bit_idx_mid[BIT_SEL_W-1:0]);
        end

        // saturate one past the frame length
        if (bit_idx_mid < BIT_IDX_W'(FRAME_BITS + 1))
            bit_idx_next = bit_idx_mid + BIT_IDX_W'(1);
        else
            bit_idx_next = bit_idx_mid;

        active_next    = active_reg || (last_time_reg == '0);
        started_next   = started_mid;
        last_time_next = last_time_reg;
        end_now        = 1'b0;
        fvalid_now     = 1'b0;
        req_now        = EDGE_NONE;

        if (bit_idx_next == BIT_IDX_W'(FRAME_BITS - 1))
        begin
            req_now = EDGE_RISE;
        end
        else if (bit_idx_next == BIT_IDX_W'(FRAME_BITS))
        begin
            if (started_mid && stop_hit)
                word_next[FRAME_BITS-1] = 1'b1;
            end_now        = 1'b1;
            fvalid_now     = started_mid;
            started_next   = 1'b0;
            active_next    = 1'b0;
            last_time_next = '0;
            req_now        = EDGE_FALL;
        end

        if (active_next)
            last_time_next = in_ch.edge_time;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_time_reg <= '0;
            active_reg    <= 1'b0;
            started_reg   <= 1'b0;
            bit_idx_reg   <= '0;
            word_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                last_time_reg <= last_time_next;
                active_reg    <= active_next;
                started_reg   <= started_next;
                bit_idx_reg   <= bit_idx_next;
                word_reg      <= word_next;
                out_valid_reg <= 1'b1;
            end
            else if (out_ch.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // result payload: load on accept, hold otherwise
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            out_word_reg   <= word_next;
            out_end_reg    <= end_now;
            out_fvalid_reg <= fvalid_now;
            out_req_reg    <= req_now;
        end
    end

    assign out_ch.valid        = out_valid_reg;
    assign out_ch.word_value   = out_word_reg;
    assign out_ch.frame_end    = out_end_reg;
    assign out_ch.frame_valid  = out_fvalid_reg;
    assign out_ch.edge_request = out_req_reg;

endmodule

`default_nettype wire

>>> sim/tb_ir_remote_pulse_decoder_top.sv
// Self-checking testbench for the IR remote pulse-interval decoder top level.
// Drives edge timestamps through the irpd_in_if/irpd_out_if channels and checks each
// result beat against an in-bench decode model; depends on irpd_pkg, irpd_if and the RTL.
`default_nettype none

module tb_ir_remote_pulse_decoder_top;
    import irpd_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int NUM_PHASES   = 8;
    localparam int PHASE_ITEMS  = 240;

    typedef struct packed {
        word_t     word;
        logic      fend;
        logic      fvalid;
        edge_req_t req;
    } decode_t;

    typedef struct {
        timer_t  stamp;
        bit      fixed;
        decode_t want;
    } dir_row_t;

    localparam decode_t DEC_IDLE = '{12'd0, 1'b0, 1'b0, EDGE_NONE};

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      cfg_we;
    cfg_idx_t  cfg_index;
    cfg_data_t cfg_data;

    irpd_in_if  in_ch ();
    irpd_out_if out_ch ();

    ir_remote_pulse_decoder_top u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (in_ch),
        .out_ch    (out_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #5 clk = ~clk;

    // decode model state and window settings
    timer_t windows [CFG_COUNT];
    timer_t prev_stamp = '0;
    logic   capturing = 1'b0;
    logic   in_frame = 1'b0;
    int     bit_pos = 0;
    word_t  word_acc = '0;

    decode_t  pending_decodes [$];
    dir_row_t directed_rows [17];
    timer_t   cur_time = '0;
    int       items_sent = 0;
    int       fail_count = 0;
    int       stall_left = 0;
    bit       idle_on = 1'b0;

    function automatic bit win_hit(timer_t gap, cfg_idx_t lo_i, cfg_idx_t hi_i);
        return gap > windows[lo_i] && gap < windows[hi_i];
    endfunction

    function automatic decode_t decode_edge(timer_t stamp);
        timer_t  gap;
        decode_t res;
        gap = stamp - prev_stamp;
        res = DEC_IDLE;
        if (win_hit(gap, CFG_START_MIN, CFG_START_MAX))
        begin
            in_frame = 1'b1;
            bit_pos  = -1;
            word_acc = '0;
        end
        if (in_frame && win_hit(gap, CFG_ONE_MIN, CFG_ONE_MAX)
            && bit_pos >= 0 && bit_pos < FRAME_BITS)
            word_acc[bit_pos] = 1'b1;
        if (bit_pos < FRAME_BITS + 1)
            bit_pos++;
        if (prev_stamp == '0)
            capturing = 1'b1;
        if (bit_pos == FRAME_BITS - 1)
            res.req = EDGE_RISE;
        else if (bit_pos == FRAME_BITS)
        begin
            if (in_frame && win_hit(gap, CFG_STOP_MIN, CFG_STOP_MAX))
                word_acc[FRAME_BITS-1] = 1'b1;
            res.fend   = 1'b1;
            res.fvalid = in_frame;
            res.req    = EDGE_FALL;
            in_frame   = 1'b0;
            capturing  = 1'b0;
            prev_stamp = '0;
        end
        if (capturing)
            prev_stamp = stamp;
        res.word = word_acc;
        return res;
    endfunction

    // mostly inside the window, sometimes right on or next to a bound
    function automatic timer_t pick_gap(cfg_idx_t lo_i, cfg_idx_t hi_i);
        timer_t lo;
        timer_t hi;
        lo = windows[lo_i];
        hi = windows[hi_i];
        if (hi <= lo || hi - lo < 2)
            return $urandom_range(1) ? lo : timer_t'($urandom);
        case ($urandom_range(9))
            0: return lo;
            1: return lo + 1;
            2: return hi - 1;
            3: return hi;
            default: return $urandom_range(hi - 1, lo + 1);
        endcase
    endfunction

    function automatic timer_t data_gap();
        case ($urandom_range(9))
            0, 1, 2, 3, 4: return pick_gap(CFG_ONE_MIN, CFG_ONE_MAX);
            5, 6: return $urandom_range(20000, 1);
            7: return pick_gap(CFG_STOP_MIN, CFG_STOP_MAX);
            8: return pick_gap(CFG_START_MIN, CFG_START_MAX);
            default: return $urandom;
        endcase
    endfunction

    function automatic timer_t stop_gap();
        case ($urandom_range(9))
            0, 1, 2, 3, 4, 5, 6: return pick_gap(CFG_STOP_MIN, CFG_STOP_MAX);
            7: return pick_gap(CFG_ONE_MIN, CFG_ONE_MAX);
            8: return $urandom_range(60000, 1);
            default: return $urandom;
        endcase
    endfunction

    task automatic check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
        if (exp_v !== act_v)
        begin
            fail_count++;
            $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, name, exp_v, act_v);
        end
    endtask

    task automatic send_edge(timer_t stamp, bit fixed = 1'b0, decode_t want = DEC_IDLE);
        decode_t got;
        if (idle_on && $urandom_range(4) == 0)
        begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(15, 1)) @(posedge clk);
        end
        in_ch.valid     <= 1'b1;
        in_ch.edge_time <= stamp;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
        // beat taken at this edge
        got = decode_edge(stamp);
        pending_decodes.push_back(fixed ? want : got);
        cur_time = stamp;
        items_sent++;
    endtask

    task automatic send_frame();
        int n_data;
        if ($urandom_range(3) != 0)
            send_edge($urandom);
        send_edge(cur_time + pick_gap(CFG_START_MIN, CFG_START_MAX));
        n_data = ($urandom_range(7) == 0) ? $urandom_range(10) : FRAME_BITS - 1;
        for (int b = 0; b < n_data; b++)
            send_edge(cur_time + data_gap());
        if (n_data == FRAME_BITS - 1)
            send_edge(cur_time + stop_gap());
    endtask

    task automatic send_noise();
        case ($urandom_range(5))
            0: send_edge($urandom);
            1: send_edge(cur_time + $urandom_range(60000));
            2: send_edge('0);
            3: send_edge('1);
            4: send_edge(cur_time);
            default: send_edge(cur_time + pick_gap(CFG_ONE_MIN, CFG_ONE_MAX));
        endcase
    endtask

    task automatic cfg_write(cfg_idx_t idx, timer_t value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        windows[idx] = value;
        @(posedge clk);
    endtask

    task automatic program_windows(timer_t s_lo, timer_t s_hi, timer_t o_lo, timer_t o_hi,
                                   timer_t p_lo, timer_t p_hi);
        cfg_write(CFG_START_MIN, s_lo);
        cfg_write(CFG_START_MAX, s_hi);
        cfg_write(CFG_ONE_MIN, o_lo);
        cfg_write(CFG_ONE_MAX, o_hi);
        cfg_write(CFG_STOP_MIN, p_lo);
        cfg_write(CFG_STOP_MAX, p_hi);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    task automatic program_random_windows(bit full_range);
        timer_t lo [3];
        timer_t hi [3];
        for (int k = 0; k < 3; k++)
        begin
            if (full_range)
            begin
                lo[k] = $urandom;
                hi[k] = $urandom;
            end
            else
            begin
                lo[k] = $urandom_range(60000, 2000);
                hi[k] = lo[k] + $urandom_range(8000, 2);
            end
        end
        program_windows(lo[0], hi[0], lo[1], hi[1], lo[2], hi[2]);
    endtask

    // drop valid and wait for every result to drain before touching the windows
    task automatic drain();
        in_ch.valid <= 1'b0;
        while (pending_decodes.size() != 0)
            @(posedge clk);
        repeat (2) @(posedge clk);
    endtask

    always @(posedge clk)
    begin
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            if (pending_decodes.size() == 0)
            begin
                fail_count++;
                $display("%0t ns: result beat with nothing expected, expected none, got %0d",
                         $time, out_ch.word_value);
            end
            else
            begin
                decode_t exp_d;
                exp_d = pending_decodes.pop_front();
                check_field("word_value", exp_d.word, out_ch.word_value);
                check_field("frame_end", exp_d.fend, out_ch.frame_end);
                check_field("frame_valid", exp_d.fvalid, out_ch.frame_valid);
                check_field("edge_request", exp_d.req, out_ch.edge_request);
            end
        end
        if (idle_on && stall_left == 0 && $urandom_range(7) == 0)
            stall_left = $urandom_range(15, 1);
        if (stall_left > 0)
        begin
            stall_left--;
            out_ch.ready <= 1'b0;
        end
        else
            out_ch.ready <= 1'b1;
    end

    initial
    begin
        #5_000_000;
        $display("simulation failed");
        $finish;
    end

    initial
    begin
        int phase_base;
        int guard;
        in_ch.valid     = 1'b0;
        in_ch.edge_time = '0;
        out_ch.ready    = 1'b0;
        cfg_we          = 1'b0;
        cfg_index       = CFG_START_MIN;
        cfg_data        = '0;
        windows[CFG_START_MIN] = START_MIN_RST;
        windows[CFG_START_MAX] = START_MAX_RST;
        windows[CFG_ONE_MIN]   = ONE_MIN_RST;
        windows[CFG_ONE_MAX]   = ONE_MAX_RST;
        windows[CFG_STOP_MIN]  = STOP_MIN_RST;
        windows[CFG_STOP_MAX]  = STOP_MAX_RST;

        // default windows: start 42000..48000, one 24000..30000, stop 15000..21000
        directed_rows = '{
            '{32'd0,          1'b1, DEC_IDLE},   // first edge after reset
            '{32'd45000,      1'b1, DEC_IDLE},   // start pulse
            '{32'd69001,      1'b0, DEC_IDLE},   // one, just above the lower bound
            '{32'd99000,      1'b0, DEC_IDLE},   // one, just below the upper bound
            '{32'd123000,     1'b0, DEC_IDLE},   // exactly on the lower bound
            '{32'd153000,     1'b0, DEC_IDLE},   // exactly on the upper bound
            '{32'd180000,     1'b0, DEC_IDLE},
            '{32'd190000,     1'b0, DEC_IDLE},
            '{32'd217000,     1'b0, DEC_IDLE},
            '{32'd244000,     1'b0, DEC_IDLE},
            '{32'd244001,     1'b0, DEC_IDLE},   // one-tick interval
            '{32'd271000,     1'b0, DEC_IDLE},
            '{32'd298000,     1'b0, DEC_IDLE},   // asks for a rising edge
            '{32'd316000,     1'b1, '{12'hED3, 1'b1, 1'b1, EDGE_FALL}},  // stop pulse
            '{32'hFFFF_FFFF,  1'b1, '{12'hED3, 1'b0, 1'b0, EDGE_NONE}},  // word held after end
            '{32'd44999,      1'b1, DEC_IDLE},   // start across the timer wrap
            '{32'd44999,      1'b0, DEC_IDLE}    // zero interval
        };

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
            send_edge(directed_rows[i].stamp, directed_rows[i].fixed, directed_rows[i].want);

        for (int ph = 0; ph < NUM_PHASES; ph++)
        begin
            drain();
            idle_on = (ph % 3 != 2) && (ph != NUM_PHASES - 1);
            case (ph)
                1: program_windows('0, '1, '0, '1, '0, '1);
                2: program_windows('1, '0, '1, '0, '1, '0);
                3: program_windows(32'd45000, 32'd45000, 32'd27000, 32'd27000,
                                   32'd18000, 32'd18000);
                4, 5: program_random_windows(1'b0);
                6: program_random_windows(1'b1);
                default: program_windows(START_MIN_RST, START_MAX_RST, ONE_MIN_RST,
                                         ONE_MAX_RST, STOP_MIN_RST, STOP_MAX_RST);
            endcase
            phase_base = items_sent;
            while (items_sent - phase_base < PHASE_ITEMS)
            begin
                if ($urandom_range(4) != 0)
                    send_frame();
                else
                    repeat ($urandom_range(5, 1)) send_noise();
            end
        end

        in_ch.valid <= 1'b0;
        guard = 0;
        while (pending_decodes.size() != 0 && guard < 1000)
        begin
            @(posedge clk);
            guard++;
        end
        if (pending_decodes.size() != 0)
        begin
            fail_count++;
            $display("%0t ns: %0d expected results never arrived", $time,
                     pending_decodes.size());
        end
        repeat (4) @(posedge clk);
        if (fail_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

`default_nettype wire
